@@ src/generational_handle_allocator_top_assert.svh @@
// assertion macros for the generational handle allocator top level
// expects clk and rst_n in the including scope
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_TOP_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define GHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/gha_pkg.sv @@
// shared types and codes for the generational handle allocator
// no dependencies
`default_nettype none

package gha_pkg;

  localparam int ACT_W     = 2;
  localparam int IDX_OUT_W = 10;
  localparam int VER_OUT_W = 22;

  typedef logic [ACT_W-1:0]     action_t;
  typedef logic [IDX_OUT_W-1:0] hidx_t;
  typedef logic [VER_OUT_W-1:0] hver_t;

  localparam action_t ACT_CREATE  = 2'd0;
  localparam action_t ACT_DESTROY = 2'd1;
  localparam action_t ACT_QUERY   = 2'd2;

endpackage

`default_nettype wire

@@ src/gha_ram.sv @@
// single write port, single read port memory with registered read data
// no dependencies
`default_nettype none

module gha_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/generational_handle_allocator_top.sv @@
// generational handle allocator: live list scan, swap-remove and lifo free stack
// depends on gha_pkg, gha_ram and generational_handle_allocator_top_assert.svh
//
//   channel | dir | handshake          | words
//   in_     | in  | in_valid / in_stall | in_action, in_handle_index, in_handle_version
//   out_    | out | out_valid/out_stall | out_ok, out_index, out_version
//
// create reuses a freed handle via ST_CREATE (free stack read), else a fresh slot
// destroy and query scan the live list, one live list read per cycle on the single
// live list read port, with the ST_DS_WR swap state added on a destroy hit
// reset clears both counts at once; the memories need no clearing pass
// a finished word waits in the output register while the next word is taken;
// a stalled output only holds back the following result
`default_nettype none

`include "generational_handle_allocator_top_assert.svh"

module generational_handle_allocator_top #(
  parameter int MAX_HANDLES  = 1024,
  parameter int VERSION_BITS = 22
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire gha_pkg::action_t in_action,
  input  wire gha_pkg::hidx_t   in_handle_index,
  input  wire gha_pkg::hver_t   in_handle_version,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_ok,
  output gha_pkg::hidx_t        out_index,
  output gha_pkg::hver_t        out_version
);

  import gha_pkg::*;

  localparam int IDX_W = $clog2(MAX_HANDLES);
  localparam int CNT_W = $clog2(MAX_HANDLES + 1);
  localparam int ENT_W = IDX_W + VERSION_BITS;
  localparam int IW_C  = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
  localparam int VW_C  = (VERSION_BITS > VER_OUT_W) ? VERSION_BITS : VER_OUT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_HANDLES);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CREATE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DS_WR  = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  action_t           act_r, act_nxt;
  hidx_t             idx_r, idx_nxt;
  hver_t             ver_r, ver_nxt;
  logic [CNT_W-1:0]  live_count_r, live_count_nxt;
  logic [CNT_W-1:0]  free_count_r, free_count_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]  cmp_pos_r, cmp_pos_nxt;
  logic              res_ok_r, res_ok_nxt;
  hidx_t             res_idx_r, res_idx_nxt;
  hver_t             res_ver_r, res_ver_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  hidx_t             out_index_r, out_index_nxt;
  hver_t             out_version_r, out_version_nxt;

  logic              ll_we, fs_we;
  logic [IDX_W-1:0]  ll_waddr, ll_raddr, fs_waddr, fs_raddr;
  logic [ENT_W-1:0]  ll_wdata, ll_rdata, fs_wdata, fs_rdata;

  logic                    in_take;
  logic                    hit;
  logic [IDX_W-1:0]        fs_idx;
  logic [VERSION_BITS-1:0] fs_ver_inc;

  gha_ram #(.DEPTH(MAX_HANDLES), .WIDTH(ENT_W)) u_live (
    .clk   (clk),
    .we    (ll_we),
    .waddr (ll_waddr),
    .wdata (ll_wdata),
    .raddr (ll_raddr),
    .rdata (ll_rdata)
  );

  gha_ram #(.DEPTH(MAX_HANDLES), .WIDTH(ENT_W)) u_free (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;

  assign hit = cmp_v_r
            && (IW_C'(ll_rdata[ENT_W-1 -: IDX_W]) == IW_C'(idx_r))
            && (VW_C'(ll_rdata[VERSION_BITS-1:0]) == VW_C'(ver_r));

  assign fs_idx     = fs_rdata[ENT_W-1 -: IDX_W];
  assign fs_ver_inc = fs_rdata[VERSION_BITS-1:0] + VERSION_BITS'(1);

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    idx_nxt         = idx_r;
    ver_nxt         = ver_r;
    live_count_nxt  = live_count_r;
    free_count_nxt  = free_count_r;
    scan_nxt        = scan_r;
    cmp_v_nxt       = cmp_v_r;
    cmp_pos_nxt     = cmp_pos_r;
    res_ok_nxt      = res_ok_r;
    res_idx_nxt     = res_idx_r;
    res_ver_nxt     = res_ver_r;
    out_valid_nxt   = out_valid_r;
    out_ok_nxt      = out_ok_r;
    out_index_nxt   = out_index_r;
    out_version_nxt = out_version_r;
    ll_we    = 1'b0;
    ll_waddr = IDX_W'(live_count_r);
    ll_wdata = '0;
    ll_raddr = IDX_W'(scan_r);
    fs_we    = 1'b0;
    fs_waddr = IDX_W'(free_count_r);
    fs_wdata = {IDX_W'(idx_r), VERSION_BITS'(ver_r)};
    fs_raddr = IDX_W'(free_count_r - CNT_W'(1));

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          act_nxt     = in_action;
          idx_nxt     = in_handle_index;
          ver_nxt     = in_handle_version;
          res_ok_nxt  = 1'b0;
          res_idx_nxt = '0;
          res_ver_nxt = '0;
          scan_nxt    = '0;
          cmp_v_nxt   = 1'b0;
          state_nxt   = ST_DONE;
          case (in_action)
            ACT_CREATE: begin
              if (live_count_r != MAX_CNT) begin
                if (free_count_r != '0) begin
                  state_nxt = ST_CREATE;
                end else begin
                  ll_we          = 1'b1;
                  ll_wdata       = {IDX_W'(live_count_r), VERSION_BITS'(0)};
                  live_count_nxt = live_count_r + CNT_W'(1);
                  res_ok_nxt     = 1'b1;
                  res_idx_nxt    = IDX_OUT_W'(live_count_r);
                end
              end
            end
            ACT_DESTROY, ACT_QUERY: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_CREATE: begin
        ll_we          = 1'b1;
        ll_wdata       = {fs_idx, fs_ver_inc};
        live_count_nxt = live_count_r + CNT_W'(1);
        free_count_nxt = free_count_r - CNT_W'(1);
        res_ok_nxt     = 1'b1;
        res_idx_nxt    = IDX_OUT_W'(fs_idx);
        res_ver_nxt    = VER_OUT_W'(fs_ver_inc);
        state_nxt      = ST_DONE;
      end
      ST_SCAN: begin
        if (hit) begin
          res_ok_nxt = 1'b1;
          if (act_r == ACT_QUERY) begin
            state_nxt = ST_DONE;
          end else begin
            ll_raddr  = IDX_W'(live_count_r - CNT_W'(1));
            state_nxt = ST_DS_WR;
          end
        end else if (scan_r == live_count_r) begin
          state_nxt = ST_DONE;
        end else begin
          cmp_v_nxt   = 1'b1;
          cmp_pos_nxt = IDX_W'(scan_r);
          scan_nxt    = scan_r + CNT_W'(1);
        end
      end
      ST_DS_WR: begin
        ll_we          = 1'b1;
        ll_waddr       = cmp_pos_r;
        ll_wdata       = ll_rdata;
        live_count_nxt = live_count_r - CNT_W'(1);
        if (free_count_r != MAX_CNT) begin
          fs_we          = 1'b1;
          free_count_nxt = free_count_r + CNT_W'(1);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_ok_nxt      = res_ok_r;
          out_index_nxt   = res_idx_r;
          out_version_nxt = res_ver_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      live_count_r <= '0;
      free_count_r <= '0;
      scan_r       <= '0;
      cmp_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      live_count_r <= live_count_nxt;
      free_count_r <= free_count_nxt;
      scan_r       <= scan_nxt;
      cmp_v_r      <= cmp_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    idx_r         <= idx_nxt;
    ver_r         <= ver_nxt;
    cmp_pos_r     <= cmp_pos_nxt;
    res_ok_r      <= res_ok_nxt;
    res_idx_r     <= res_idx_nxt;
    res_ver_r     <= res_ver_nxt;
    out_ok_r      <= out_ok_nxt;
    out_index_r   <= out_index_nxt;
    out_version_r <= out_version_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_ok      = out_ok_r;
  assign out_index   = out_index_r;
  assign out_version = out_version_r;

  `GHA_ASSERT_IMP(a_count_bound, 1'b1, ((CNT_W+1)'(live_count_r) + (CNT_W+1)'(free_count_r)) <= (CNT_W+1)'(MAX_HANDLES), "live plus free count exceeds table size")
  `GHA_ASSERT_NXT(a_take_busy, in_take, state_r != ST_IDLE, "accepted word did not start work")
  `GHA_ASSERT_NXT(a_destroy_dec, state_r == ST_DS_WR, live_count_r == $past(live_count_r) - CNT_W'(1), "destroy did not shrink live list")
  `GHA_ASSERT_IMP(a_fail_zero, out_valid_r && !out_ok_r, out_index_r == '0 && out_version_r == '0, "failed word carries a handle")

endmodule

`default_nettype wire

@@ tb/generational_handle_allocator_checker.sv @@
// result checker for the generational handle allocator: predicts every result word
// from its own handle tables and compares it with what the block hands out
// depends on gha_pkg
`timescale 1ns / 1ps

module generational_handle_allocator_checker #(
  parameter int MAX_HANDLES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  gha_pkg::action_t in_action,
  input  gha_pkg::hidx_t   in_handle_index,
  input  gha_pkg::hver_t   in_handle_version,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             out_ok,
  input  gha_pkg::hidx_t   out_index,
  input  gha_pkg::hver_t   out_version,
  output int               fail_count,
  output int               results_pending
);

  import gha_pkg::*;

  typedef struct packed {
    logic  ok;
    hidx_t idx;
    hver_t ver;
  } alloc_result_t;

  hidx_t live_idx  [MAX_HANDLES];
  hver_t live_ver  [MAX_HANDLES];
  hidx_t freed_idx [MAX_HANDLES];
  hver_t freed_ver [MAX_HANDLES];
  int live_n;
  int freed_n;
  int mismatches;
  alloc_result_t expected_results [$];

  initial begin
    live_n = 0;
    freed_n = 0;
    mismatches = 0;
    fail_count = 0;
    results_pending = 0;
  end

  function automatic int find_live_slot(hidx_t i, hver_t v);
    int k;
    for (k = 0; k < live_n; k++) begin
      if (live_idx[k] == i && live_ver[k] == v) return k;
    end
    return -1;
  endfunction

  task automatic apply_handle_op(input action_t a, input hidx_t i, input hver_t v,
                                 output alloc_result_t r);
    int slot;
    hidx_t hi;
    hver_t hv;
    r = '0;
    case (a)
      ACT_CREATE: begin
        if (live_n < MAX_HANDLES) begin
          if (freed_n > 0) begin
            freed_n--;
            hi = freed_idx[freed_n];
            hv = freed_ver[freed_n] + 1'b1;
          end else begin
            hi = hidx_t'(live_n);
            hv = '0;
          end
          live_idx[live_n] = hi;
          live_ver[live_n] = hv;
          live_n++;
          r.ok = 1'b1;
          r.idx = hi;
          r.ver = hv;
        end
      end
      ACT_DESTROY: begin
        slot = find_live_slot(i, v);
        if (slot >= 0) begin
          live_idx[slot] = live_idx[live_n-1];
          live_ver[slot] = live_ver[live_n-1];
          live_n--;
          if (freed_n < MAX_HANDLES) begin
            freed_idx[freed_n] = i;
            freed_ver[freed_n] = v;
            freed_n++;
          end
          r.ok = 1'b1;
        end
      end
      ACT_QUERY: begin
        r.ok = (find_live_slot(i, v) >= 0);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    alloc_result_t want;
    if (!rst_n) begin
      live_n = 0;
      freed_n = 0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        apply_handle_op(in_action, in_handle_index, in_handle_version, want);
        expected_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t unexpected word: expected none, actual ok %0b index %0d version %0d",
                   $time, out_ok, out_index, out_version);
        end else begin
          want = expected_results.pop_front();
          if (want.ok !== out_ok) begin
            mismatches++;
            $display("%0t ok mismatch: expected %0b, actual %0b", $time, want.ok, out_ok);
          end
          if (want.idx !== out_index) begin
            mismatches++;
            $display("%0t index mismatch: expected %0d, actual %0d",
                     $time, want.idx, out_index);
          end
          if (want.ver !== out_version) begin
            mismatches++;
            $display("%0t version mismatch: expected %0d, actual %0d",
                     $time, want.ver, out_version);
          end
        end
      end
    end
    fail_count <= mismatches;
    results_pending <= expected_results.size();
  end

endmodule

@@ tb/generational_handle_allocator_top_tb.sv @@
// stimulus and verdict for the generational handle allocator: directed words,
// random create/destroy/query traffic with idling, then a final probe of live handles
// depends on gha_pkg, generational_handle_allocator_top and the result checker
`timescale 1ns / 1ps

module generational_handle_allocator_top_tb;
  import gha_pkg::*;

  localparam action_t ACT_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    hidx_t idx;
    hver_t ver;
  } handle_word_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  action_t in_action = ACT_CREATE;
  hidx_t   in_handle_index = '0;
  hver_t   in_handle_version = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  logic    out_ok;
  hidx_t   out_index;
  hver_t   out_version;
  int      fail_count;
  int      results_pending;
  int      cycle_count = 0;
  int      snd_gap_pct = 0;
  int      rcv_stall_pct = 0;

  handle_word_t live_pool [$];
  handle_word_t retired_pool [$];
  action_t issued_actions [$];

  generational_handle_allocator_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_handle_index   (in_handle_index),
    .in_handle_version (in_handle_version),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_index         (out_index),
    .out_version       (out_version)
  );

  generational_handle_allocator_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_handle_index   (in_handle_index),
    .in_handle_version (in_handle_version),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_index         (out_index),
    .out_version       (out_version),
    .fail_count        (fail_count),
    .results_pending   (results_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  // learn handles handed out by creates
  always @(posedge clk) begin : learn
    action_t a;
    if (rst_n && out_valid && !out_stall && issued_actions.size() != 0) begin
      a = issued_actions.pop_front();
      if (a == ACT_CREATE && out_ok) live_pool.push_back({out_index, out_version});
    end
  end

  task automatic issue_word(input action_t a, input hidx_t i, input hver_t v);
    int k;
    if ($urandom_range(99) < snd_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= a;
    in_handle_index <= i;
    in_handle_version <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    issued_actions.push_back(a);
    if (a == ACT_DESTROY) begin
      for (k = live_pool.size() - 1; k >= 0; k--) begin
        if (live_pool[k].idx == i && live_pool[k].ver == v) begin
          live_pool.delete(k);
          retired_pool.push_back({i, v});
          if (retired_pool.size() > 64) void'(retired_pool.pop_front());
        end
      end
    end
  endtask

  task automatic random_word();
    int r;
    int k;
    handle_word_t h;
    r = $urandom_range(99);
    if (r < 10) begin
      issue_word(action_t'($urandom_range(3)), hidx_t'($urandom), hver_t'($urandom));
    end else if (r < 17 && retired_pool.size() != 0) begin
      h = retired_pool[$urandom_range(retired_pool.size() - 1)];
      issue_word($urandom_range(1) ? ACT_DESTROY : ACT_QUERY, h.idx, h.ver);
    end else if (r < 25 && live_pool.size() != 0) begin
      h = live_pool[$urandom_range(live_pool.size() - 1)];
      if ($urandom_range(3) == 0) begin
        h.idx ^= hidx_t'(1) << $urandom_range(9);
        issue_word(ACT_QUERY, h.idx, h.ver);
      end else begin
        h.ver ^= hver_t'(1) << $urandom_range(21);
        issue_word($urandom_range(1) ? ACT_DESTROY : ACT_QUERY, h.idx, h.ver);
      end
    end else if ((r < 60 && live_pool.size() < 40) || live_pool.size() == 0) begin
      issue_word(ACT_CREATE, hidx_t'($urandom), hver_t'($urandom));
    end else begin
      k = $urandom_range(live_pool.size() - 1);
      issue_word(r < 82 ? ACT_DESTROY : ACT_QUERY, live_pool[k].idx, live_pool[k].ver);
    end
  endtask

  initial begin : stimulus
    handle_word_t h;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_gap_pct = 8;
    rcv_stall_pct = 46;
    issue_word(ACT_QUERY, '0, '0);
    issue_word(ACT_DESTROY, '0, '0);
    issue_word(ACT_CREATE, '1, '1);
    issue_word(ACT_CREATE, '0, '0);
    issue_word(ACT_CREATE, '0, '0);
    issue_word(ACT_QUERY, 10'd1, '0);
    issue_word(ACT_QUERY, '1, '1);
    issue_word(ACT_QUERY, 10'd1, 22'd1);
    issue_word(ACT_DESTROY, '0, '0);
    issue_word(ACT_DESTROY, '0, '0);
    issue_word(ACT_QUERY, 10'd2, '0);
    issue_word(ACT_DESTROY, 10'd1, '0);
    issue_word(ACT_CREATE, '0, '0);
    issue_word(ACT_CREATE, '0, '0);
    issue_word(ACT_CREATE, '0, '0);
    issue_word(ACT_NOP, '1, '1);
    issue_word(ACT_NOP, '0, '0);
    issue_word(ACT_DESTROY, 10'd3, '0);
    issue_word(ACT_QUERY, 10'd3, '0);
    issue_word(ACT_CREATE, '0, '0);
    issue_word(ACT_DESTROY, '1, '1);
    repeat (185) random_word();

    snd_gap_pct = 46;
    rcv_stall_pct = 8;
    repeat (185) random_word();

    snd_gap_pct = 0;
    rcv_stall_pct = 0;
    repeat (185) random_word();

    // probe a live handle, then reuse what was freed
    if (live_pool.size() != 0) begin
      h = live_pool[$urandom_range(live_pool.size() - 1)];
      issue_word(ACT_QUERY, h.idx, h.ver);
      issue_word(ACT_DESTROY, h.idx, h.ver);
    end
    issue_word(ACT_CREATE, '0, '0);
    issue_word(ACT_CREATE, '0, '0);
    issue_word(ACT_QUERY, '1, '1);
    in_valid <= 1'b0;

    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/gha_pkg.sv
src/gha_ram.sv
src/generational_handle_allocator_top.sv
tb/generational_handle_allocator_checker.sv
tb/generational_handle_allocator_top_tb.sv
